### rtl/fcte_pkg.sv
`default_nettype none

package fcte_pkg;

   localparam int unsigned OP_W        = 3;
   localparam int unsigned VAL_W       = 28;
   localparam int unsigned BA_W        = 14;
   localparam int unsigned BD_W        = 8;
   localparam int unsigned ST_W        = 2;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned CNT_W       = 12;
   localparam int unsigned CL_W        = CNT_W + 1;
   localparam int unsigned EA_W        = CL_W + 2;
   localparam int unsigned ACC_W       = 32;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 12;
   localparam int unsigned REQ_TDATA_W = 80;
   localparam int unsigned RSP_TDATA_W = 32;

   localparam logic [VAL_W-1:0] GEN_BAD       = 28'h0ffffff7;
   localparam logic [VAL_W-1:0] GEN_EOC       = 28'h0fffffff;
   localparam logic [11:0]      NAT12_BAD     = 12'hff7;
   localparam logic [11:0]      NAT12_EOC     = 12'hff8;
   localparam logic [15:0]      NAT16_BAD     = 16'hfff7;
   localparam logic [15:0]      NAT16_EOC     = 16'hfff8;
   localparam logic [VAL_W-1:0] NAT32_BAD     = 28'h0ffffff7;
   localparam logic [VAL_W-1:0] NAT32_EOC     = 28'h0ffffff8;
   localparam logic [CL_W-1:0]  FIRST_CLUSTER = 13'd2;
   localparam logic [CNT_W-1:0] COUNT_RESET   = 12'd4094;

   typedef enum logic [OP_W-1:0] {
      OP_READ    = 3'd0,
      OP_WRITE   = 3'd1,
      OP_ALLOC   = 3'd2,
      OP_COUNT   = 3'd3,
      OP_BYTE_WR = 3'd4,
      OP_BYTE_RD = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      STS_OK      = 2'd0,
      STS_FULL    = 2'd1,
      STS_RANGE   = 2'd2,
      STS_REFUSED = 2'd3
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FAT12 = 2'd0,
      KIND_FAT16 = 2'd1,
      KIND_FAT32 = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_KIND    = 1'd0,
      CSR_CLUSTER_COUNT = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_CLUSTER,
      CUR_ALLOC,
      CUR_FIRST,
      CUR_NEXT
   } cur_op_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_READ,
      S_LATCH,
      S_EVAL,
      S_WRITE,
      S_BYTE_WR,
      S_BYTE_RD,
      S_BYTE_CAP,
      S_RESP
   } ctl_state_type;

   typedef struct packed {
      logic       accept;
      logic       clr_wr;
      logic       mem_rd_entry;
      logic       mem_wr_entry;
      logic       mem_rd_byte;
      logic       mem_wr_byte;
      logic       k_clr;
      logic       k_inc;
      logic       latch;
      cur_op_type cur_op;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       res_entry;
      logic       res_cur;
      logic       res_inc;
      logic       res_byte;
      logic       ss_update;
      logic       st_set;
      status_type st_value;
      logic       out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            cl_ok;
      logic            ev_zero;
      logic            n_zero;
      logic            k_last;
      logic            entry_free;
      logic            kind12;
      logic            clr_last;
      logic            at_last;
      logic            scan_last;
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/fcte_ctrl.sv
`default_nettype none

module fcte_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   input  fcte_pkg::dp_stat_type stat,
   output fcte_pkg::ctl_cmd_type cmd
);

   fcte_pkg::ctl_state_type state_ff, state_in;
   logic                    rsp_tvalid_ff;
   logic                    out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == fcte_pkg::S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fcte_pkg::S_CLEAR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcte_pkg::S_CLEAR: begin
            if (stat.clr_last) state_in = fcte_pkg::S_IDLE;
         end
         fcte_pkg::S_IDLE: begin
            if (req_tvalid) state_in = fcte_pkg::S_START;
         end
         fcte_pkg::S_START: begin
            unique case (stat.op)
               fcte_pkg::OP_READ: begin
                  state_in = stat.cl_ok ? fcte_pkg::S_READ : fcte_pkg::S_RESP;
               end
               fcte_pkg::OP_WRITE: begin
                  if (!stat.cl_ok) state_in = fcte_pkg::S_RESP;
                  else if (stat.kind12) state_in = fcte_pkg::S_READ;
                  else state_in = fcte_pkg::S_WRITE;
               end
               fcte_pkg::OP_ALLOC: begin
                  state_in = (stat.ev_zero || stat.n_zero) ? fcte_pkg::S_RESP
                                                           : fcte_pkg::S_READ;
               end
               fcte_pkg::OP_COUNT: begin
                  state_in = stat.n_zero ? fcte_pkg::S_RESP : fcte_pkg::S_READ;
               end
               fcte_pkg::OP_BYTE_WR: state_in = fcte_pkg::S_BYTE_WR;
               fcte_pkg::OP_BYTE_RD: state_in = fcte_pkg::S_BYTE_RD;
               default:              state_in = fcte_pkg::S_RESP;
            endcase
         end
         fcte_pkg::S_READ:  state_in = fcte_pkg::S_LATCH;
         fcte_pkg::S_LATCH: begin
            state_in = stat.k_last ? fcte_pkg::S_EVAL : fcte_pkg::S_READ;
         end
         fcte_pkg::S_EVAL: begin
            unique case (stat.op)
               fcte_pkg::OP_WRITE: state_in = fcte_pkg::S_WRITE;
               fcte_pkg::OP_ALLOC: begin
                  if (stat.entry_free) state_in = fcte_pkg::S_WRITE;
                  else if (stat.scan_last) state_in = fcte_pkg::S_RESP;
                  else state_in = fcte_pkg::S_READ;
               end
               fcte_pkg::OP_COUNT: begin
                  state_in = stat.at_last ? fcte_pkg::S_RESP : fcte_pkg::S_READ;
               end
               default: state_in = fcte_pkg::S_RESP;
            endcase
         end
         fcte_pkg::S_WRITE: begin
            if (stat.k_last) state_in = fcte_pkg::S_RESP;
         end
         fcte_pkg::S_BYTE_WR:  state_in = fcte_pkg::S_RESP;
         fcte_pkg::S_BYTE_RD:  state_in = fcte_pkg::S_BYTE_CAP;
         fcte_pkg::S_BYTE_CAP: state_in = fcte_pkg::S_RESP;
         fcte_pkg::S_RESP: begin
            if (out_free) state_in = fcte_pkg::S_IDLE;
         end
         default: state_in = fcte_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         fcte_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
         fcte_pkg::S_IDLE:  cmd.accept = req_tvalid;
         fcte_pkg::S_START: begin
            cmd.k_clr = 1'b1;
            unique case (stat.op) inside
               fcte_pkg::OP_READ, fcte_pkg::OP_WRITE: begin
                  if (stat.cl_ok) begin
                     cmd.cur_op = fcte_pkg::CUR_CLUSTER;
                  end else begin
                     cmd.st_set   = 1'b1;
                     cmd.st_value = fcte_pkg::STS_RANGE;
                  end
               end
               fcte_pkg::OP_ALLOC: begin
                  if (stat.ev_zero) begin
                     cmd.st_set   = 1'b1;
                     cmd.st_value = fcte_pkg::STS_REFUSED;
                  end else if (stat.n_zero) begin
                     cmd.st_set   = 1'b1;
                     cmd.st_value = fcte_pkg::STS_FULL;
                  end else begin
                     cmd.cur_op  = fcte_pkg::CUR_ALLOC;
                     cmd.cnt_clr = 1'b1;
                  end
               end
               fcte_pkg::OP_COUNT: cmd.cur_op = fcte_pkg::CUR_FIRST;
               default: ;
            endcase
         end
         fcte_pkg::S_READ: cmd.mem_rd_entry = 1'b1;
         fcte_pkg::S_LATCH: begin
            cmd.latch = 1'b1;
            cmd.k_inc = 1'b1;
         end
         fcte_pkg::S_EVAL: begin
            cmd.k_clr = 1'b1;
            unique case (stat.op)
               fcte_pkg::OP_READ: cmd.res_entry = 1'b1;
               fcte_pkg::OP_ALLOC: begin
                  if (stat.entry_free) begin
                     cmd.res_cur   = 1'b1;
                     cmd.ss_update = 1'b1;
                  end else if (stat.scan_last) begin
                     cmd.st_set   = 1'b1;
                     cmd.st_value = fcte_pkg::STS_FULL;
                  end else begin
                     cmd.cnt_inc = 1'b1;
                     cmd.cur_op  = fcte_pkg::CUR_NEXT;
                  end
               end
               fcte_pkg::OP_COUNT: begin
                  cmd.res_inc = stat.entry_free;
                  if (!stat.at_last) cmd.cur_op = fcte_pkg::CUR_NEXT;
               end
               default: ;
            endcase
         end
         fcte_pkg::S_WRITE: begin
            cmd.mem_wr_entry = 1'b1;
            cmd.k_inc        = 1'b1;
         end
         fcte_pkg::S_BYTE_WR:  cmd.mem_wr_byte = 1'b1;
         fcte_pkg::S_BYTE_RD:  cmd.mem_rd_byte = 1'b1;
         fcte_pkg::S_BYTE_CAP: cmd.res_byte    = 1'b1;
         fcte_pkg::S_RESP:     cmd.out_load    = out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/fcte_datapath.sv
`default_nettype none

module fcte_datapath #(
   parameter int unsigned IMAGE_BYTES  = 16384,
   parameter int unsigned MAX_CLUSTERS = 4094
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire  [fcte_pkg::REQ_TDATA_W-1:0]        req_tdata,
   input  wire  [fcte_pkg::OP_W-1:0]               req_tuser,
   input  wire                                     csr_valid,
   input  wire  [fcte_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire  [fcte_pkg::CSR_DATA_W-1:0]         csr_data,
   input  fcte_pkg::ctl_cmd_type                   cmd,
   output fcte_pkg::dp_stat_type                   stat,
   output logic [fcte_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [fcte_pkg::ST_W-1:0]               rsp_tuser
);

   localparam int unsigned MAW = $clog2(IMAGE_BYTES);
   localparam int unsigned AXW = ((MAW > fcte_pkg::EA_W) ? MAW : fcte_pkg::EA_W) + 1;
   localparam int unsigned CNT_MAX = (1 << fcte_pkg::CNT_W) - 1;
   localparam int unsigned CAP = (MAX_CLUSTERS > CNT_MAX) ? CNT_MAX : MAX_CLUSTERS;

   logic [fcte_pkg::KIND_W-1:0] kind_ff;
   logic [fcte_pkg::CNT_W-1:0]  count_ff;
   logic [fcte_pkg::CL_W-1:0]   ss_ff;
   logic [MAW-1:0]              clr_ff;
   logic [1:0]                  k_ff;

   logic [fcte_pkg::OP_W-1:0]   op_ff;
   logic [fcte_pkg::VAL_W-1:0]  cl_ff;
   logic [fcte_pkg::VAL_W-1:0]  ev_ff;
   logic [fcte_pkg::BA_W-1:0]   ba_ff;
   logic [fcte_pkg::BD_W-1:0]   bd_ff;
   logic [fcte_pkg::CL_W-1:0]   cur_ff, cur_in;
   logic [fcte_pkg::CNT_W-1:0]  cnt_ff;
   logic [fcte_pkg::ACC_W-1:0]  acc_ff;
   logic [fcte_pkg::VAL_W-1:0]  res_ff;
   fcte_pkg::status_type        st_ff;
   logic [7:0]                  rd_ff;
   logic                        rd_ok_ff;
   logic [fcte_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [fcte_pkg::ST_W-1:0]   rsp_tuser_ff;

   logic [7:0]                  mem [IMAGE_BYTES];

   logic [fcte_pkg::CNT_W-1:0]  n_eff;
   logic [fcte_pkg::CL_W-1:0]   last_cl;
   logic [fcte_pkg::CL_W-1:0]   nxt_cl;
   logic                        ss_ok;
   logic                        is12, is16, is32;
   logic [fcte_pkg::EA_W-1:0]   base_addr;
   logic [fcte_pkg::EA_W-1:0]   entry_addr;
   logic [AXW-1:0]              addr_x;
   logic                        in_img;
   logic                        mem_we;
   logic                        mem_re;
   logic [7:0]                  mem_wdata;
   logic [7:0]                  cap_byte;
   logic [11:0]                 raw12;
   logic [15:0]                 raw16;
   logic [fcte_pkg::VAL_W-1:0]  raw32;
   logic [fcte_pkg::VAL_W-1:0]  dec_val;
   logic [11:0]                 v12;
   logic [15:0]                 d12;
   logic [15:0]                 v16;
   logic [fcte_pkg::VAL_W-1:0]  v28;
   logic [fcte_pkg::ACC_W-1:0]  enc_word;

   assign is12 = (kind_ff == fcte_pkg::KIND_FAT12);
   assign is16 = (kind_ff == fcte_pkg::KIND_FAT16);
   assign is32 = kind_ff[1];

   assign n_eff   = (count_ff > fcte_pkg::CNT_W'(CAP)) ? fcte_pkg::CNT_W'(CAP) : count_ff;
   assign last_cl = {1'b0, n_eff} + fcte_pkg::CL_W'(1);
   assign nxt_cl  = (cur_ff == last_cl) ? fcte_pkg::FIRST_CLUSTER
                                        : cur_ff + fcte_pkg::CL_W'(1);
   assign ss_ok   = (ss_ff >= fcte_pkg::FIRST_CLUSTER) && (ss_ff <= last_cl);

   always_comb begin
      if (is32) begin
         base_addr = {cur_ff, 2'b00};
      end else if (is16) begin
         base_addr = {1'b0, cur_ff, 1'b0};
      end else begin
         base_addr = fcte_pkg::EA_W'(cur_ff) + fcte_pkg::EA_W'(cur_ff[fcte_pkg::CL_W-1:1]);
      end
   end
   assign entry_addr = base_addr + fcte_pkg::EA_W'(k_ff);

   always_comb begin
      if (cmd.clr_wr) begin
         addr_x = AXW'(clr_ff);
      end else if (cmd.mem_rd_byte || cmd.mem_wr_byte) begin
         addr_x = AXW'(ba_ff);
      end else begin
         addr_x = AXW'(entry_addr);
      end
   end
   assign in_img = (addr_x < AXW'(IMAGE_BYTES));
   assign mem_we = cmd.clr_wr || cmd.mem_wr_entry || cmd.mem_wr_byte;
   assign mem_re = cmd.mem_rd_entry || cmd.mem_rd_byte;

   // Entry decode: native bad and end-of-chain codes become the generic ones.
   assign raw12 = cur_ff[0] ? acc_ff[15:4] : acc_ff[11:0];
   assign raw16 = acc_ff[15:0];
   assign raw32 = acc_ff[fcte_pkg::VAL_W-1:0];

   always_comb begin
      if (is32) begin
         if (raw32 == fcte_pkg::NAT32_BAD) dec_val = fcte_pkg::GEN_BAD;
         else if (raw32 >= fcte_pkg::NAT32_EOC) dec_val = fcte_pkg::GEN_EOC;
         else dec_val = raw32;
      end else if (is16) begin
         if (raw16 == fcte_pkg::NAT16_BAD) dec_val = fcte_pkg::GEN_BAD;
         else if (raw16 >= fcte_pkg::NAT16_EOC) dec_val = fcte_pkg::GEN_EOC;
         else dec_val = fcte_pkg::VAL_W'(raw16);
      end else begin
         if (raw12 == fcte_pkg::NAT12_BAD) dec_val = fcte_pkg::GEN_BAD;
         else if (raw12 >= fcte_pkg::NAT12_EOC) dec_val = fcte_pkg::GEN_EOC;
         else dec_val = fcte_pkg::VAL_W'(raw12);
      end
   end

   // Entry encode: a packed twelve-bit entry shares a nibble with its neighbor.
   always_comb begin
      if (ev_ff == fcte_pkg::GEN_BAD) begin
         v12 = fcte_pkg::NAT12_BAD;
         v16 = fcte_pkg::NAT16_BAD;
         v28 = fcte_pkg::NAT32_BAD;
      end else if (ev_ff == fcte_pkg::GEN_EOC) begin
         v12 = fcte_pkg::NAT12_EOC;
         v16 = fcte_pkg::NAT16_EOC;
         v28 = fcte_pkg::NAT32_EOC;
      end else begin
         v12 = ev_ff[11:0];
         v16 = ev_ff[15:0];
         v28 = ev_ff;
      end
      d12 = cur_ff[0] ? {v12, acc_ff[3:0]} : {acc_ff[15:12], v12};
      if (is32) begin
         enc_word = {4'h0, v28};
      end else if (is16) begin
         enc_word = {16'h0, v16};
      end else begin
         enc_word = {16'h0, d12};
      end
   end

   always_comb begin
      if (cmd.clr_wr) begin
         mem_wdata = 8'h00;
      end else if (cmd.mem_wr_byte) begin
         mem_wdata = bd_ff;
      end else begin
         mem_wdata = enc_word[{k_ff, 3'b000} +: 8];
      end
   end

   assign cap_byte = rd_ok_ff ? rd_ff : 8'h00;

   always_comb begin
      unique case (cmd.cur_op)
         fcte_pkg::CUR_CLUSTER: cur_in = cl_ff[fcte_pkg::CL_W-1:0];
         fcte_pkg::CUR_ALLOC:   cur_in = ss_ok ? ss_ff : fcte_pkg::FIRST_CLUSTER;
         fcte_pkg::CUR_FIRST:   cur_in = fcte_pkg::FIRST_CLUSTER;
         fcte_pkg::CUR_NEXT:    cur_in = nxt_cl;
         default:               cur_in = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we && in_img) begin
         mem[addr_x[MAW-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff    <= mem[addr_x[MAW-1:0]];
         rd_ok_ff <= in_img;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= fcte_pkg::KIND_FAT12;
         count_ff <= fcte_pkg::COUNT_RESET;
         ss_ff    <= fcte_pkg::FIRST_CLUSTER;
         clr_ff   <= '0;
         k_ff     <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               fcte_pkg::CSR_TABLE_KIND:    kind_ff  <= csr_data[fcte_pkg::KIND_W-1:0];
               fcte_pkg::CSR_CLUSTER_COUNT: count_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.ss_update) ss_ff <= nxt_cl;
         if (cmd.clr_wr) clr_ff <= clr_ff + MAW'(1);
         if (cmd.k_clr) begin
            k_ff <= '0;
         end else if (cmd.k_inc) begin
            k_ff <= k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_tuser;
         cl_ff  <= req_tdata[27:0];
         ev_ff  <= req_tdata[55:28];
         ba_ff  <= req_tdata[69:56];
         bd_ff  <= req_tdata[77:70];
         res_ff <= '0;
         st_ff  <= fcte_pkg::STS_OK;
      end else begin
         if (cmd.st_set) st_ff <= cmd.st_value;
         if (cmd.res_entry) begin
            res_ff <= dec_val;
         end else if (cmd.res_cur) begin
            res_ff <= fcte_pkg::VAL_W'(cur_ff);
         end else if (cmd.res_inc) begin
            res_ff <= res_ff + fcte_pkg::VAL_W'(1);
         end else if (cmd.res_byte) begin
            res_ff <= fcte_pkg::VAL_W'(cap_byte);
         end
      end
      cur_ff <= cur_in;
      if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + fcte_pkg::CNT_W'(1);
      end
      if (cmd.latch) acc_ff[{k_ff, 3'b000} +: 8] <= cap_byte;
      if (cmd.out_load) begin
         rsp_tdata_ff <= fcte_pkg::RSP_TDATA_W'(res_ff);
         rsp_tuser_ff <= st_ff;
      end
   end

   assign stat.op         = op_ff;
   assign stat.cl_ok      = (cl_ff >= fcte_pkg::VAL_W'(fcte_pkg::FIRST_CLUSTER)) &&
                            (cl_ff <= fcte_pkg::VAL_W'(last_cl));
   assign stat.ev_zero    = (ev_ff == '0);
   assign stat.n_zero     = (n_eff == '0);
   assign stat.k_last     = is32 ? (k_ff == 2'd3) : (k_ff == 2'd1);
   assign stat.entry_free = is32 ? (raw32 == '0) : (is16 ? (raw16 == '0) : (raw12 == '0));
   assign stat.kind12     = is12;
   assign stat.clr_last   = (clr_ff == MAW'(IMAGE_BYTES - 1));
   assign stat.at_last    = (cur_ff == last_cl);
   assign stat.scan_last  = (cnt_ff == n_eff - fcte_pkg::CNT_W'(1));

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule

`default_nettype wire

### rtl/fat_cluster_table_engine_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata, tuser (operation)
// rsp       out        rsp_tvalid/rsp_tready  tdata, tuser (status)
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// After reset the image is cleared one byte per cycle, before
// the first word is accepted; register writes are taken throughout.
// One word is processed at a time through a single-byte memory port; each byte read is
// issued, then latched; an entry read covers two bytes for 12/16-bit tables, four for 32-bit.
// Allocation and counting read and evaluate each entry in turn; allocation then writes the free entry.
// A finished word waits in the output register while the next word is accepted.

module fat_cluster_table_engine_unit #(
   parameter int unsigned IMAGE_BYTES  = 16384,
   parameter int unsigned MAX_CLUSTERS = 4094
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // cluster[27:0], entry_value[55:28], byte_address[69:56], byte_data[77:70], zero
   input  wire  [79:0] req_tdata,
   // operation[2:0]
   input  wire  [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // result_value[27:0], zero
   output logic [31:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [0:0]  csr_index,
   input  wire  [11:0] csr_data
);

   fcte_pkg::ctl_cmd_type cmd;
   fcte_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   fcte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fcte_datapath #(
      .IMAGE_BYTES  (IMAGE_BYTES),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire
